[rtl/lrc_pkg.sv]
`timescale 1ns / 1ps

package lrc_pkg;

    // geometry of the cache array
    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 3;
    localparam int RANK_W   = 3;

    // field widths
    localparam int ADDR_IN_W = 32;
    localparam int HIT_W     = 32;
    localparam int SETLOG_W  = 3;
    localparam int WAYCNT_W  = 4;

    // configuration register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // largest usable set count log2
    localparam logic [SETLOG_W-1:0] SETLOG_MAX = SETLOG_W'(SET_W);

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_SET_COUNT_LOG2 = 1'b0,
        REG_WAY_COUNT      = 1'b1
    } reg_index_t;

    // input item
    typedef struct packed
    {
        logic [ADDR_IN_W-1:0] access_address;
    } access_t;

    // result item
    typedef struct packed
    {
        logic             hit;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way_index;
        logic [HIT_W-1:0] hit_total;
    } result_t;

    // outcome of one set lookup
    typedef struct packed
    {
        logic             hit;
        logic [WAY_W-1:0] way;
    } lookup_t;

    // rank of a way in a set that was never written
    function automatic logic [RANK_W-1:0] reset_rank(input int unsigned way);
        return RANK_W'(way);
    endfunction

endpackage

[rtl/lrc_chan_if.sv]
`timescale 1ns / 1ps

interface lrc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

    modport monitor
    (
        input valid,
        input data,
        input ready
    );
endinterface

[rtl/lru_set_associative_cache_lookup_core.sv]
`timescale 1ns / 1ps

// Set-associative cache lookup with LRU replacement. Each access runs in two
// steps: in the first the set row (tags, valid bits and recency ranks of all
// ways) is read from a single-port-read RAM, in the second all ways are
// compared in parallel, the row is written back and the result is loaded
// into the output register. A new access waits for the last to complete, as
// this read-then-write-back of one RAM row sets the rate. A waiting result
// stalls only the second step. One flip-flop per set marks rows never
// written, so no clearing pass runs after reset. The user (not the block)
// writes configuration over the APB port only while no access is in flight.
module lru_set_associative_cache_lookup_core #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lrc_chan_if.sink                    access,
    lrc_chan_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrc_pkg::PADDR_W-1:0] paddr,
    input  logic [lrc_pkg::PDATA_W-1:0] pwdata,
    output logic [lrc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lrc_pkg::*;

    localparam int TAG_W = (ADDRESS_BITS < ADDR_IN_W) ? ADDRESS_BITS : ADDR_IN_W;
    localparam int ROW_W = MAX_WAYS * (1 + RANK_W + TAG_W);

    // configuration registers
    logic [SETLOG_W-1:0] set_count_log2_reg;
    logic [WAYCNT_W-1:0] way_count_reg;
    logic                cfg_write;
    reg_index_t          cfg_index;

    // lookup control
    logic                busy_reg, busy_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [MAX_SETS-1:0] row_live_reg;
    logic [HIT_W-1:0]    hits_seen_reg, hits_next;
    logic                out_valid_reg;
    result_t             out_data_reg;
    logic                accept;
    logic                complete;
    logic [SETLOG_W-1:0] set_log;
    logic [SET_W-1:0]    set_mask;

    // row storage
    logic [ROW_W-1:0]                 rdata;
    logic [ROW_W-1:0]                 wdata;
    logic [MAX_WAYS-1:0]              q_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  q_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   q_tag;
    logic [MAX_WAYS-1:0]              n_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  n_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   n_tag;
    lookup_t                          lookup;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_SET_COUNT_LOG2: prdata = PDATA_W'(set_count_log2_reg);
            REG_WAY_COUNT:      prdata = PDATA_W'(way_count_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_log2_reg <= SETLOG_MAX;
            way_count_reg      <= WAYCNT_W'(MAX_WAYS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SET_COUNT_LOG2: set_count_log2_reg <= pwdata[SETLOG_W-1:0];
                REG_WAY_COUNT:      way_count_reg      <= pwdata[WAYCNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // handshakes
    assign access.ready = !busy_reg;
    assign accept       = access.valid & access.ready;
    assign complete     = busy_reg & (!out_valid_reg | result.ready);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // set from the low address bits
    assign set_log  = (set_count_log2_reg > SETLOG_MAX) ? SETLOG_MAX : set_count_log2_reg;
    assign set_mask = ~({SET_W{1'b1}} << set_log);

    always_comb
    begin
        busy_next = busy_reg;
        set_next  = set_reg;
        tag_next  = tag_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            set_next  = access.data.access_address[SET_W-1:0] & set_mask;
            tag_next  = access.data.access_address[TAG_W-1:0];
        end
        else if (complete)
        begin
            busy_next = 1'b0;
        end
    end

    // saturating hit count
    assign hits_next = (lookup.hit && (hits_seen_reg != '1)) ?
                       hits_seen_reg + HIT_W'(1) : hits_seen_reg;

    // set rows: valid bits, recency ranks, tags
    lrc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (complete),
        .waddr (set_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (set_next),
        .rdata (rdata)
    );

    assign {q_valid, q_rank, q_tag} = rdata;
    assign wdata = {n_valid, n_rank, n_tag};

    lrc_set_update #(
        .TAG_W (TAG_W)
    ) u_set_update (
        .row_live  (row_live_reg[set_reg]),
        .way_count (way_count_reg),
        .tag       (tag_reg),
        .valid_in  (q_valid),
        .rank_in   (q_rank),
        .tag_in    (q_tag),
        .lookup    (lookup),
        .valid_out (n_valid),
        .rank_out  (n_rank),
        .tag_out   (n_tag)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_live_reg  <= '0;
            hits_seen_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (complete)
            begin
                row_live_reg[set_reg] <= 1'b1;
                hits_seen_reg         <= hits_next;
                out_valid_reg         <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        tag_reg <= tag_next;
        if (complete)
        begin
            out_data_reg.hit       <= lookup.hit;
            out_data_reg.set_index <= set_reg;
            out_data_reg.way_index <= lookup.way;
            out_data_reg.hit_total <= hits_next;
        end
    end
endmodule

[rtl/lrc_ram.sv]
`timescale 1ns / 1ps

module lrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/lrc_set_update.sv]
`timescale 1ns / 1ps

module lrc_set_update #(
    parameter int TAG_W = 32
) (
    input  logic                                           row_live,
    input  logic [lrc_pkg::WAYCNT_W-1:0]                   way_count,
    input  logic [TAG_W-1:0]                               tag,
    input  logic [lrc_pkg::MAX_WAYS-1:0]                   valid_in,
    input  logic [lrc_pkg::MAX_WAYS-1:0][lrc_pkg::RANK_W-1:0] rank_in,
    input  logic [lrc_pkg::MAX_WAYS-1:0][TAG_W-1:0]        tag_in,
    output lrc_pkg::lookup_t                               lookup,
    output logic [lrc_pkg::MAX_WAYS-1:0]                   valid_out,
    output logic [lrc_pkg::MAX_WAYS-1:0][lrc_pkg::RANK_W-1:0] rank_out,
    output logic [lrc_pkg::MAX_WAYS-1:0][TAG_W-1:0]        tag_out
);
    import lrc_pkg::*;

    logic [WAYCNT_W-1:0]              ways;
    logic [MAX_WAYS-1:0]              active;
    logic [MAX_WAYS-1:0]              valid_cur;
    logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_cur;
    logic [MAX_WAYS-1:0]              match;
    logic                             hit;
    logic [WAY_W-1:0]                 hit_way;
    logic                             free_found;
    logic [WAY_W-1:0]                 free_way;
    logic [RANK_W-1:0]                best;
    logic [WAY_W-1:0]                 lru_way;
    logic [WAY_W-1:0]                 way;
    logic [RANK_W-1:0]                old_rank;

    // clamp the way count to 1..MAX_WAYS
    always_comb
    begin
        if (way_count == '0)
        begin
            ways = WAYCNT_W'(1);
        end
        else if (way_count > WAYCNT_W'(MAX_WAYS))
        begin
            ways = WAYCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways = way_count;
        end
    end

    // a row never written reads as its reset contents
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            active[w]    = WAYCNT_W'(w) < ways;
            valid_cur[w] = row_live & valid_in[w];
            rank_cur[w]  = row_live ? rank_in[w] : reset_rank(w);
            match[w]     = active[w] & valid_cur[w] & (tag_in[w] == tag);
        end
    end

    // lowest matching way and lowest free way
    always_comb
    begin
        hit_way    = '0;
        free_way   = '0;
        free_found = 1'b0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (active[w] && !valid_cur[w])
            begin
                free_way   = WAY_W'(w);
                free_found = 1'b1;
            end
        end
        hit = |match;
    end

    // oldest active way, lowest number on ties
    always_comb
    begin
        best    = rank_cur[0];
        lru_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (active[w] && (rank_cur[w] > best))
            begin
                best    = rank_cur[w];
                lru_way = WAY_W'(w);
            end
        end
    end

    // pick the way, then age the younger ways and fill on a miss
    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (free_found)
        begin
            way = free_way;
        end
        else
        begin
            way = lru_way;
        end

        old_rank  = rank_cur[way];
        valid_out = valid_cur;
        tag_out   = tag_in;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (rank_cur[w] < old_rank)
            begin
                rank_out[w] = rank_cur[w] + RANK_W'(1);
            end
            else
            begin
                rank_out[w] = rank_cur[w];
            end
        end
        rank_out[way] = '0;
        if (!hit)
        begin
            valid_out[way] = 1'b1;
            tag_out[way]   = tag;
        end

        lookup.hit = hit;
        lookup.way = way;
    end
endmodule

[rtl/lrc_checker.sv]
`timescale 1ns / 1ps

module lrc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             access_valid,
    input logic             access_ready,
    input logic             result_valid,
    input logic             result_ready,
    input lrc_pkg::result_t result_data
);
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

    // one access in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && access_ready |=> !access_ready)
    else $error("access taken while another is in flight");

    // a newly raised result valid traces back to an access transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(access_valid && access_ready, 2))
    else $error("result without a preceding access");

    // a hit always shows a nonzero hit total
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.hit |-> result_data.hit_total != '0)
    else $error("hit reported with zero hit total");
endmodule

bind lru_set_associative_cache_lookup_core lrc_checker u_lrc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .access_valid (access.valid),
    .access_ready (access.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

[tb/lru_set_associative_cache_lookup_core_tb.sv]
`timescale 1ns / 1ps

module lru_set_associative_cache_lookup_core_tb;

    import lrc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 250000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ACCESSES = 105;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 40;

    // result checker holding its own copy of the cache array
    class lru_scoreboard;
        logic [ADDR_IN_W-1:0] line_tag [MAX_SETS][MAX_WAYS];
        bit                   line_used [MAX_SETS][MAX_WAYS];
        bit [RANK_W-1:0]      line_rank [MAX_SETS][MAX_WAYS];
        bit [HIT_W-1:0]       hit_count;
        bit [SETLOG_W-1:0]    set_log;
        bit [WAYCNT_W-1:0]    way_cnt;
        result_t              pending_lookups [$];
        int                   fail_count;
        int                   checked;
        int                   hits_checked;

        function new();
            for (int s = 0; s < MAX_SETS; s++)
            begin
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    line_tag[s][w]  = '0;
                    line_used[s][w] = 1'b0;
                    line_rank[s][w] = RANK_W'(w);
                end
            end
            hit_count    = '0;
            set_log      = SETLOG_W'(6);
            way_cnt      = WAYCNT_W'(8);
            fail_count   = 0;
            checked      = 0;
            hits_checked = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_SET_COUNT_LOG2)
                set_log = value[SETLOG_W-1:0];
            else
                way_cnt = value[WAYCNT_W-1:0];
        endfunction

        // look up one address, update the array and queue the expected result
        function void predict_lookup(logic [ADDR_IN_W-1:0] addr);
            int              sl;
            int              ways;
            int              set_no;
            int              way_no;
            bit              is_hit;
            bit              found;
            bit [RANK_W-1:0] oldest;
            bit [RANK_W-1:0] old_rank;
            result_t         r;
            sl     = (set_log > 6) ? 6 : int'(set_log);
            ways   = (way_cnt == 0) ? 1 : ((way_cnt > MAX_WAYS) ? MAX_WAYS : int'(way_cnt));
            set_no = int'(addr[SET_W-1:0]) & ((1 << sl) - 1);
            is_hit = 1'b0;
            way_no = 0;

            // lowest matching active way wins
            for (int w = 0; w < ways; w++)
            begin
                if (!is_hit && line_used[set_no][w] && line_tag[set_no][w] == addr)
                begin
                    is_hit = 1'b1;
                    way_no = w;
                end
            end

            if (is_hit)
            begin
                if (hit_count != '1)
                    hit_count++;
            end
            else
            begin
                // victim: first invalid active way, else the oldest active way
                found = 1'b0;
                for (int w = 0; w < ways; w++)
                begin
                    if (!found && !line_used[set_no][w])
                    begin
                        found  = 1'b1;
                        way_no = w;
                    end
                end
                if (!found)
                begin
                    way_no = 0;
                    oldest = line_rank[set_no][0];
                    for (int w = 1; w < ways; w++)
                    begin
                        if (line_rank[set_no][w] > oldest)
                        begin
                            oldest = line_rank[set_no][w];
                            way_no = w;
                        end
                    end
                end
                line_tag[set_no][way_no]  = addr;
                line_used[set_no][way_no] = 1'b1;
            end

            // move touched way to the front, age all younger ways
            old_rank = line_rank[set_no][way_no];
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (line_rank[set_no][w] < old_rank)
                    line_rank[set_no][w]++;
            end
            line_rank[set_no][way_no] = '0;

            r.hit       = is_hit;
            r.set_index = SET_W'(set_no);
            r.way_index = WAY_W'(way_no);
            r.hit_total = hit_count;
            pending_lookups.push_back(r);
        endfunction

        task report(string msg);
            if (fail_count < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
            fail_count++;
        endtask

        task check_result(result_t got);
            result_t exp;
            if (pending_lookups.size() == 0)
            begin
                report("result transfer with no lookup outstanding");
                return;
            end
            exp = pending_lookups.pop_front();
            checked++;
            if (exp.hit)
                hits_checked++;
            if (got.hit !== exp.hit)
                report($sformatf("hit %b, expected %b", got.hit, exp.hit));
            if (got.set_index !== exp.set_index)
                report($sformatf("set_index %0d, expected %0d", got.set_index, exp.set_index));
            if (got.way_index !== exp.way_index)
                report($sformatf("way_index %0d, expected %0d", got.way_index, exp.way_index));
            if (got.hit_total !== exp.hit_total)
                report($sformatf("hit_total %0d, expected %0d", got.hit_total, exp.hit_total));
        endtask

        function int outstanding();
            return pending_lookups.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lrc_chan_if #(.payload_t(access_t)) access_ch ();
    lrc_chan_if #(.payload_t(result_t)) result_ch ();

    lru_scoreboard sb = new();

    int unsigned cycle_count;
    int          accesses_sent;
    int          geometries;
    bit          hold_request;

    lru_set_associative_cache_lookup_core uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .access  (access_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        access_ch.valid  = 1'b0;
        access_ch.data   = '0;
        result_ch.ready  = 1'b0;
        hold_request     = 1'b0;
        accesses_sent    = 0;
        geometries       = 0;
    end

    // monitor both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (access_ch.valid && access_ch.ready)
                sb.predict_lookup(access_ch.data.access_address);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.data);
        end
    end

    // result side: random stall pattern plus one long hold-off
    initial
    begin
        int run_left;
        int stall_left;
        int hold_left;
        bit hold_done;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (run_left == 0 && stall_left == 0)
                begin
                    run_left   = $urandom_range(1, 24);
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                if (run_left > 0)
                begin
                    result_ch.ready <= 1'b1;
                    run_left--;
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    stall_left--;
                end
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lru_set_associative_cache_lookup_core test failed");
        $finish;
    end

    // offer one access and hold it until the transfer
    task send_access(logic [ADDR_IN_W-1:0] addr);
        @(negedge clk);
        access_ch.valid <= 1'b1;
        access_ch.data  <= addr;
        do
            @(posedge clk);
        while (!access_ch.ready);
        accesses_sent++;
    endtask

    // drop valid for a gap whose length is set by n; no gap when n is zero
    task sender_gap(int n);
        if (n > 0)
        begin
            @(negedge clk);
            access_ch.valid <= 1'b0;
            repeat (n - 1) @(posedge clk);
        end
    endtask

    // stop offering and wait until every lookup has returned
    task drain_lookups();
        sender_gap(1);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task write_cache_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task set_geometry(int setlog, int waycnt);
        drain_lookups();
        write_cache_reg(REG_SET_COUNT_LOG2, PDATA_W'(setlog));
        write_cache_reg(REG_WAY_COUNT, PDATA_W'(waycnt));
        geometries++;
    endtask

    // one phase of random traffic: mostly a small pool of addresses crowded
    // into a few sets so that hits and evictions are frequent
    task random_phase(int phase_no);
        logic [ADDR_IN_W-1:0] pool [16];
        logic [SET_W-1:0]     hot_sets [3];
        logic [ADDR_IN_W-1:0] addr;
        int                   burst_left;
        burst_left = 0;
        foreach (hot_sets[i])
            hot_sets[i] = SET_W'($urandom_range(0, MAX_SETS - 1));
        foreach (pool[i])
            pool[i] = {(ADDR_IN_W - SET_W)'($urandom()), hot_sets[$urandom_range(0, 2)]};
        for (int n = 0; n < PHASE_ACCESSES; n++)
        begin
            if (burst_left == 0)
            begin
                sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 20);
            end
            if ($urandom_range(0, 3) == 0)
                addr = $urandom();
            else
                addr = pool[$urandom_range(0, 15)];
            // receiver holds off while a long burst keeps coming
            if (phase_no == 2 && n == 40)
            begin
                hold_request = 1'b1;
                burst_left   = PHASE_ACCESSES;
            end
            send_access(addr);
            burst_left--;
        end
    endtask

    initial
    begin
        logic [ADDR_IN_W-1:0] warmup [15];
        int fixed_setlog [4];
        int fixed_waycnt [4];

        warmup = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'd5, 32'd69, 32'd133, 32'd197,
                   32'd261, 32'd325, 32'd389, 32'd453, 32'd517,
                   32'd69, 32'd5};
        fixed_setlog = '{6, 0, 7, 2};
        fixed_waycnt = '{8, 1, 9, 3};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: address extremes, nine lines into one set to force
        // an eviction, then a hit on a surviving line and a refill
        foreach (warmup[i])
            send_access(warmup[i]);

        // oversized set count and zero way count clamp to 64 sets, 1 way
        set_geometry(7, 0);
        send_access(32'h0000_0040);
        send_access(32'h0000_0040);

        // one set, two ways: fill the empty way
        set_geometry(0, 2);
        send_access(32'h0000_0080);
        // shrink to one way: the same address refills way 0
        set_geometry(0, 1);
        send_access(32'h0000_0080);
        // oversized way count: two ways now match, the lower one is taken
        set_geometry(0, 15);
        send_access(32'h0000_0080);

        // random traffic over a spread of geometries
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
                set_geometry(fixed_setlog[p], fixed_waycnt[p]);
            else
                set_geometry($urandom_range(0, 7), $urandom_range(0, 15));
            random_phase(p);
        end

        drain_lookups();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d lookups never returned", sb.outstanding()));

        $display("covered %0d accesses over %0d cache geometries", accesses_sent, geometries);
        $display("results checked: %0d hits, %0d misses, %0d mismatches",
                 sb.hits_checked, sb.checked - sb.hits_checked, sb.fail_count);
        if (sb.fail_count == 0)
            $display("lru_set_associative_cache_lookup_core test passed");
        else
            $display("lru_set_associative_cache_lookup_core test failed");
        $finish;
    end

endmodule

[lru_set_associative_cache_lookup_core.f]
rtl/lrc_pkg.sv
rtl/lrc_chan_if.sv
rtl/lrc_ram.sv
rtl/lrc_set_update.sv
rtl/lru_set_associative_cache_lookup_core.sv
rtl/lrc_checker.sv
tb/lru_set_associative_cache_lookup_core_tb.sv
